// ===== hdl/lcpe_pkg.sv =====
`default_nettype none

package lcpe_pkg;

   localparam int ChanW      = 8;
   localparam int TickW      = 15;
   localparam int BitsPerLed = 24;
   localparam int CntW       = $clog2(BitsPerLed);
   localparam int ScaleShift = 6;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 15;

   localparam logic [CsrIdxW-1:0] RegBrightness = 3'd0;
   localparam logic [CsrIdxW-1:0] RegZeroHigh   = 3'd1;
   localparam logic [CsrIdxW-1:0] RegZeroLow    = 3'd2;
   localparam logic [CsrIdxW-1:0] RegOneHigh    = 3'd3;
   localparam logic [CsrIdxW-1:0] RegOneLow     = 3'd4;

   localparam logic [ChanW-1:0] ResetBrightness = 8'd8;
   localparam logic [TickW-1:0] ResetZeroHigh   = 15'd12;
   localparam logic [TickW-1:0] ResetZeroLow    = 15'd36;
   localparam logic [TickW-1:0] ResetOneHigh    = 15'd24;
   localparam logic [TickW-1:0] ResetOneLow     = 15'd24;

   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
      logic             final_led;
   } req_type;

   typedef struct packed {
      logic [TickW-1:0] high_ticks;
      logic [TickW-1:0] low_ticks;
      logic             bit_value;
      logic             led_done;
      logic             frame_done;
   } rsp_type;

   typedef struct packed {
      logic [TickW-1:0] zero_high;
      logic [TickW-1:0] zero_low;
      logic [TickW-1:0] one_high;
      logic [TickW-1:0] one_low;
   } timing_type;

   typedef struct packed {
      logic [BitsPerLed-1:0] grb;
      logic                  final_led;
   } word_type;

endpackage

`default_nettype wire

// ===== hdl/lcpe_csr.sv =====
`default_nettype none

module lcpe_csr #(
   parameter int MAX_LEVEL = 8,
   parameter int LevelW    = 4,
   parameter int NumW      = 8
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_write,
   input  wire  [lcpe_pkg::CsrIdxW-1:0]  csr_index,
   input  wire  [lcpe_pkg::CsrDataW-1:0] csr_wdata,
   output logic [NumW-1:0]               level_sq,
   output lcpe_pkg::timing_type          timing
);
   import lcpe_pkg::*;

   localparam int ResetLevel = (int'(ResetBrightness) > MAX_LEVEL) ?
                               MAX_LEVEL : int'(ResetBrightness);
   localparam int ResetNum   = ResetLevel * ResetLevel;

   logic [NumW-1:0]   level_sq_ff, level_sq_in;
   timing_type        timing_ff, timing_in;
   logic [LevelW-1:0] level;

   always_comb begin
      if (csr_wdata[ChanW-1:0] > ChanW'(MAX_LEVEL)) begin
         level = LevelW'(MAX_LEVEL);
      end else begin
         level = csr_wdata[LevelW-1:0];
      end
   end

   always_comb begin
      level_sq_in = level_sq_ff;
      timing_in   = timing_ff;
      if (csr_write) begin
         case (csr_index)
            RegBrightness: level_sq_in = NumW'(level) * NumW'(level);
            RegZeroHigh:   timing_in.zero_high = csr_wdata[TickW-1:0];
            RegZeroLow:    timing_in.zero_low  = csr_wdata[TickW-1:0];
            RegOneHigh:    timing_in.one_high  = csr_wdata[TickW-1:0];
            RegOneLow:     timing_in.one_low   = csr_wdata[TickW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_sq_ff        <= NumW'(ResetNum);
         timing_ff.zero_high <= ResetZeroHigh;
         timing_ff.zero_low  <= ResetZeroLow;
         timing_ff.one_high  <= ResetOneHigh;
         timing_ff.one_low   <= ResetOneLow;
      end else begin
         level_sq_ff <= level_sq_in;
         timing_ff   <= timing_in;
      end
   end

   assign level_sq = level_sq_ff;
   assign timing   = timing_ff;

endmodule

`default_nettype wire

// ===== hdl/lcpe_scale.sv =====
`default_nettype none

module lcpe_scale #(
   parameter int NumW = 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  lcpe_pkg::req_type    req_payload,
   input  wire  [NumW-1:0]      level_sq,
   output logic                 word_valid,
   input  wire                  word_pop,
   output lcpe_pkg::word_type   word
);
   import lcpe_pkg::*;

   localparam int ProdW = ChanW + NumW;

   function automatic logic [ChanW-1:0] scale_chan(input logic [ChanW-1:0] c,
                                                   input logic [NumW-1:0]  n);
      logic [ProdW-1:0] prod;
      logic [ProdW-1:0] quo;
      begin
         prod = ProdW'(c) * ProdW'(n);
         quo  = prod >> ScaleShift;
         if (quo > ProdW'({ChanW{1'b1}})) begin
            scale_chan = {ChanW{1'b1}};
         end else begin
            scale_chan = quo[ChanW-1:0];
         end
      end
   endfunction

   logic     valid_ff, valid_in;
   word_type word_ff, word_in;
   logic     accept;

   assign req_stall = valid_ff && !word_pop;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      word_in.grb       = {scale_chan(req_payload.green, level_sq),
                           scale_chan(req_payload.red, level_sq),
                           scale_chan(req_payload.blue, level_sq)};
      word_in.final_led = req_payload.final_led;
      if (accept) begin
         valid_in = 1'b1;
      end else if (word_pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

`default_nettype wire

// ===== hdl/lcpe_serial.sv =====
`default_nettype none

module lcpe_serial (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  word_valid,
   output logic                 word_pop,
   input  lcpe_pkg::word_type   word,
   input  lcpe_pkg::timing_type timing,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output lcpe_pkg::rsp_type    rsp_payload
);
   import lcpe_pkg::*;

   localparam logic [CntW-1:0] LastBit = CntW'(BitsPerLed - 1);

   logic                  active_ff, active_in;
   logic [BitsPerLed-1:0] shift_ff, shift_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic                  final_ff, final_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  out_free;
   logic                  advance;
   logic                  last;
   logic                  bit_now;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = active_ff && out_free;
   assign last     = (cnt_ff == LastBit);
   assign word_pop = word_valid && (!active_ff || (advance && last));
   assign bit_now  = shift_ff[BitsPerLed-1];

   always_comb begin
      active_in    = active_ff;
      shift_in     = shift_ff;
      cnt_in       = cnt_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in       = 1'b1;
         rsp_in.high_ticks  = bit_now ? timing.one_high : timing.zero_high;
         rsp_in.low_ticks   = bit_now ? timing.one_low : timing.zero_low;
         rsp_in.bit_value   = bit_now;
         rsp_in.led_done    = last;
         rsp_in.frame_done  = last && final_ff;
         shift_in           = {shift_ff[BitsPerLed-2:0], 1'b0};
         cnt_in             = cnt_ff + 1'b1;
         if (last) begin
            active_in = 1'b0;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (word_pop) begin
         active_in = 1'b1;
         shift_in  = word.grb;
         final_in  = word.final_led;
         cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
      final_ff <= final_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/led_chain_pixel_encoder_top.sv =====
// Path: an accepted request is registered in the scale buffer, then popped into the
// serializer, whose output register holds its first symbol. Throughput: one symbol per
// cycle while rsp_stall is low, set by the one-bit-per-cycle shift register of the
// serializer. A one-request buffer takes the next request as the current one shifts out.
// Reset: synchronous, active high; clears all valid flags and restores the registers
// to brightness 8 and timing 12/36/24/24.
`default_nettype none

module led_chain_pixel_encoder_top #(
   parameter int MAX_LEVEL = 8
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  lcpe_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output lcpe_pkg::rsp_type             rsp_payload,
   input  wire                           csr_write,
   input  wire  [lcpe_pkg::CsrIdxW-1:0]  csr_index,
   input  wire  [lcpe_pkg::CsrDataW-1:0] csr_wdata
);
   import lcpe_pkg::*;

   localparam int LevelW = $clog2(MAX_LEVEL + 1);
   localparam int NumW   = 2 * LevelW;

   logic [NumW-1:0] level_sq;
   timing_type      timing;
   logic            word_valid;
   logic            word_pop;
   word_type        word;

   lcpe_csr #(
      .MAX_LEVEL (MAX_LEVEL),
      .LevelW    (LevelW),
      .NumW      (NumW)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .level_sq  (level_sq),
      .timing    (timing)
   );

   lcpe_scale #(
      .NumW (NumW)
   ) u_scale (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .level_sq    (level_sq),
      .word_valid  (word_valid),
      .word_pop    (word_pop),
      .word        (word)
   );

   lcpe_serial u_serial (
      .clock       (clock),
      .reset       (reset),
      .word_valid  (word_valid),
      .word_pop    (word_pop),
      .word        (word),
      .timing      (timing),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_frame_on_led_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_payload.frame_done || rsp_payload.led_done))
      else $error("frame_done without led_done");

   a_accept_fills_buffer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> word_valid)
      else $error("accepted request not buffered");

   a_buffer_holds: assert property (@(posedge clock) disable iff (reset)
      (word_valid && !word_pop) |=> (word_valid && $stable(word)))
      else $error("buffered request lost or changed");

   a_pop_needs_word: assert property (@(posedge clock) disable iff (reset)
      word_pop |-> word_valid)
      else $error("pop from empty buffer");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import lcpe_pkg::*;

   localparam int MaxLevel   = 8;
   localparam int QuietLimit = 2000;
   localparam int PressureAt = 2000;
   localparam int PressureHold = 150;

   localparam logic [CsrIdxW-1:0] FirstUnusedReg = 3'd5;
   localparam logic [CsrIdxW-1:0] LastUnusedReg  = 3'd7;

   typedef enum logic {RowWrite, RowPixel} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CsrIdxW-1:0]    index;
      logic [CsrDataW-1:0]   wdata;
      req_type               px;
      logic                  typed;
      logic [BitsPerLed-1:0] grb;
   } stim_row_type;

   localparam stim_row_type Plan [33] = '{
      '{RowPixel, '0, '0, '{8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, 24'h000000},
      '{RowPixel, '0, '0, '{8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, 24'hFFFFFF},
      '{RowPixel, '0, '0, '{8'h12, 8'hA5, 8'h3C, 1'b0}, 1'b1, 24'hA5123C},
      '{RowPixel, '0, '0, '{8'h80, 8'h01, 8'h7F, 1'b1}, 1'b1, 24'h01807F},
      '{RowWrite, RegBrightness, 15'h0000, '0, 1'b0, '0},
      '{RowPixel, '0, '0, '{8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, 24'h000000},
      '{RowPixel, '0, '0, '{8'h5A, 8'hC3, 8'h96, 1'b0}, 1'b1, 24'h000000},
      '{RowWrite, RegBrightness, 15'h00FF, '0, 1'b0, '0},
      '{RowPixel, '0, '0, '{8'h5A, 8'hC3, 8'h96, 1'b1}, 1'b1, 24'hC35A96},
      '{RowWrite, RegBrightness, 15'h7F09, '0, 1'b0, '0},
      '{RowPixel, '0, '0, '{8'h01, 8'h80, 8'hFE, 1'b0}, 1'b1, 24'h8001FE},
      '{RowWrite, RegBrightness, 15'h0004, '0, 1'b0, '0},
      '{RowPixel, '0, '0, '{8'hFF, 8'h80, 8'h03, 1'b0}, 1'b0, '0},
      '{RowWrite, RegBrightness, 15'h0001, '0, 1'b0, '0},
      '{RowPixel, '0, '0, '{8'hFF, 8'h7F, 8'h40, 1'b1}, 1'b0, '0},
      '{RowWrite, RegBrightness, 15'h0007, '0, 1'b0, '0},
      '{RowPixel, '0, '0, '{8'hAA, 8'h55, 8'hC8, 1'b0}, 1'b0, '0},
      '{RowWrite, RegZeroHigh, 15'h0000, '0, 1'b0, '0},
      '{RowWrite, RegZeroLow, 15'h7FFF, '0, 1'b0, '0},
      '{RowWrite, RegOneHigh, 15'h0001, '0, 1'b0, '0},
      '{RowWrite, RegOneLow, 15'h7FFF, '0, 1'b0, '0},
      '{RowWrite, RegBrightness, 15'h0008, '0, 1'b0, '0},
      '{RowPixel, '0, '0, '{8'h0F, 8'hF0, 8'h3C, 1'b1}, 1'b1, 24'hF00F3C},
      '{RowWrite, FirstUnusedReg, 15'h7FFF, '0, 1'b0, '0},
      '{RowWrite, LastUnusedReg, 15'h0000, '0, 1'b0, '0},
      '{RowPixel, '0, '0, '{8'h3C, 8'h0F, 8'hF0, 1'b0}, 1'b1, 24'h0F3CF0},
      '{RowWrite, RegZeroHigh, 15'h7FFF, '0, 1'b0, '0},
      '{RowWrite, RegZeroLow, 15'h0001, '0, 1'b0, '0},
      '{RowWrite, RegOneHigh, 15'h7FFF, '0, 1'b0, '0},
      '{RowWrite, RegOneLow, 15'h0000, '0, 1'b0, '0},
      '{RowPixel, '0, '0, '{8'h81, 8'h42, 8'h24, 1'b1}, 1'b1, 24'h428124},
      '{RowWrite, RegBrightness, 15'h0003, '0, 1'b0, '0},
      '{RowPixel, '0, '0, '{8'hFF, 8'hFF, 8'h00, 1'b0}, 1'b0, '0}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_payload;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_payload;
   logic                csr_write;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   logic [ChanW-1:0] brightness_reg = ResetBrightness;
   timing_type       tick_reg = '{ResetZeroHigh, ResetZeroLow, ResetOneHigh, ResetOneLow};

   rsp_type symbol_q[$];
   rsp_type want_sym;
   bit      fast_mode;
   int      quiet_cycles;
   int      mismatch_count;
   int      symbols_seen;
   int      requests_sent;
   int      frames_sent;
   int      writes_done;

   led_chain_pixel_encoder_top #(
      .MAX_LEVEL(MaxLevel)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [ChanW-1:0] dim_channel(input logic [ChanW-1:0] c,
                                                    input int unsigned num);
      int unsigned v;
      v = (int'(c) * num) >> ScaleShift;
      return (v > 255) ? 8'hFF : v[ChanW-1:0];
   endfunction

   function automatic logic [BitsPerLed-1:0] scaled_grb(input req_type px);
      int unsigned level;
      int unsigned num;
      level = (brightness_reg > MaxLevel) ? MaxLevel : brightness_reg;
      num   = level * level;
      return {dim_channel(px.green, num), dim_channel(px.red, num), dim_channel(px.blue, num)};
   endfunction

   function automatic void push_symbols(input logic [BitsPerLed-1:0] grb, input logic last);
      rsp_type sym;
      for (int k = 0; k < BitsPerLed; k++) begin
         sym.bit_value  = grb[BitsPerLed-1-k];
         sym.high_ticks = sym.bit_value ? tick_reg.one_high : tick_reg.zero_high;
         sym.low_ticks  = sym.bit_value ? tick_reg.one_low : tick_reg.zero_low;
         sym.led_done   = (k == BitsPerLed - 1);
         sym.frame_done = sym.led_done & last;
         symbol_q.push_back(sym);
      end
   endfunction

   function automatic logic [TickW-1:0] pick_ticks();
      case ($urandom_range(0, 7))
         0: return TickW'(1);
         1: return '1;
         2: return '0;
         3, 4: return TickW'($urandom_range(1, 64));
         default: return TickW'($urandom_range(1, 32767));
      endcase
   endfunction

   function automatic logic [ChanW-1:0] rand_channel();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return ChanW'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      req_valid = 1'b0;
      while (symbol_q.size() != 0) @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      case (idx)
         RegBrightness: brightness_reg = data[ChanW-1:0];
         RegZeroHigh:   tick_reg.zero_high = data;
         RegZeroLow:    tick_reg.zero_low = data;
         RegOneHigh:    tick_reg.one_high = data;
         RegOneLow:     tick_reg.one_low = data;
         default: ;
      endcase
      writes_done++;
   endtask

   task automatic send_request(input req_type px, input logic typed,
                               input logic [BitsPerLed-1:0] grb);
      int gap;
      gap = fast_mode ? 0 : $urandom_range(0, 5);
      csr_write = 1'b0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = px;
      do @(posedge clock); while (req_stall);
      push_symbols(typed ? grb : scaled_grb(px), px.final_led);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic random_settings();
      logic [CsrDataW-1:0] level;
      case ($urandom_range(0, 3))
         0: level = CsrDataW'($urandom_range(0, 9));
         1: level = CsrDataW'($urandom_range(0, 32767));
         2: level = CsrDataW'(ResetBrightness);
         default: level = CsrDataW'($urandom_range(0, 2));
      endcase
      write_reg(RegBrightness, level);
      write_reg(RegZeroHigh, pick_ticks());
      write_reg(RegZeroLow, pick_ticks());
      write_reg(RegOneHigh, pick_ticks());
      write_reg(RegOneLow, pick_ticks());
      if ($urandom_range(0, 2) == 0)
         write_reg(CsrIdxW'($urandom_range(FirstUnusedReg, LastUnusedReg)),
                   CsrDataW'($urandom));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         symbols_seen++;
         if (symbol_q.size() == 0) begin
            $error("symbol arrived with no request pending");
            mismatch_count++;
         end else begin
            want_sym = symbol_q.pop_front();
            check_field("high_ticks", want_sym.high_ticks, rsp_payload.high_ticks);
            check_field("low_ticks", want_sym.low_ticks, rsp_payload.low_ticks);
            check_field("bit_value", want_sym.bit_value, rsp_payload.bit_value);
            check_field("led_done", want_sym.led_done, rsp_payload.led_done);
            check_field("frame_done", want_sym.frame_done, rsp_payload.frame_done);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
         $display("no handshake for %0d cycles, %0d symbols outstanding",
                  QuietLimit, symbol_q.size());
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : symbol_sink
      int  hold;
      bit  pressured;
      rsp_stall = 1'b0;
      pressured = 1'b0;
      @(negedge clock);
      forever begin
         hold = fast_mode ? 0 : $urandom_range(0, 5);
         // hold off long enough to back the block up into its input
         if (!pressured && symbols_seen >= PressureAt) begin
            hold      = PressureHold;
            pressured = 1'b1;
         end
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   initial begin : led_source
      req_type px;
      int      frame_len;
      int      sent_in_phase;
      bit      broken;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_write   = 1'b0;
      csr_index   = RegBrightness;
      csr_wdata   = '0;
      fast_mode   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < $size(Plan); i++) begin
         if (Plan[i].kind == RowWrite)
            write_reg(Plan[i].index, Plan[i].wdata);
         else
            send_request(Plan[i].px, Plan[i].typed, Plan[i].grb);
      end

      for (int phase = 0; phase < 9; phase++) begin
         random_settings();
         fast_mode     = (phase % 4 == 2);
         sent_in_phase = 0;
         while (sent_in_phase < 30) begin
            frame_len = $urandom_range(1, 8);
            broken    = ($urandom_range(0, 9) == 0);
            for (int led = 0; led < frame_len; led++) begin
               px.red       = rand_channel();
               px.green     = rand_channel();
               px.blue      = rand_channel();
               px.final_led = broken ? 1'($urandom_range(0, 1)) : (led == frame_len - 1);
               send_request(px, 1'b0, '0);
               sent_in_phase++;
            end
            frames_sent++;
         end
         fast_mode = 1'b0;
      end

      req_valid = 1'b0;
      while (symbol_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Encoded %0d LEDs (%0d random frames), %0d symbols checked, %0d register writes",
               requests_sent, frames_sent, symbols_seen, writes_done);
      $display("Brightness 0..255 incl. saturation and black, timing extremes 0/1/32767");
      if (mismatch_count == 0 && symbol_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
